// File: design/assert_macros.svh
// assertion macros used by the receiver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(name, clk, rst, ante, cons)
`define ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// File: design/saw_pkg.sv
// shared types, widths and result codes for the stop-and-wait receiver
package saw_pkg;

  localparam int PAYLOAD_BYTES_DEF = 32;
  localparam int LENGTH_BITS_DEF   = 16;

  localparam int BYTE_W    = 8;
  localparam int CSUM_W    = 32;
  localparam int KIND_W    = 2;
  localparam int LEN_OUT_W = 16;

  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 3;

  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NACK = 2'd2;

  typedef struct packed {
    logic take;
    logic emit_byte;
    logic emit_resp;
  } saw_cmd_t;

  typedef struct packed {
    logic pass;
    logic drain_empty;
    logic drain_last;
    logic out_free;
  } saw_stat_t;

endpackage

// File: design/saw_ctrl.sv
// controller state machine: packet accept, buffer drain and response
module saw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tlast,
  input  saw_pkg::saw_stat_t  stat,
  output logic                s_tready,
  output saw_pkg::saw_cmd_t   cmd
);
  import saw_pkg::*;

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_START  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_RESP   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.take      = 1'b0;
    cmd.emit_byte = 1'b0;
    cmd.emit_resp = 1'b0;
    case (state)
      ST_ACCEPT: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        // read of the first buffered byte is in flight
        if (stat.pass && !stat.drain_empty) begin
          state_next = ST_DRAIN;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_DRAIN: begin
        if (stat.out_free) begin
          cmd.emit_byte = 1'b1;
          if (stat.drain_last) begin
            state_next = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.emit_resp = 1'b1;
          state_next    = ST_ACCEPT;
        end
      end
      default: begin
        state_next = ST_ACCEPT;
      end
    endcase
  end

endmodule

// File: design/saw_dpath.sv
// datapath: payload buffer, checksum sum, message length and output register
module saw_dpath #(
  parameter int PAYLOAD_BYTES = saw_pkg::PAYLOAD_BYTES_DEF,
  parameter int LENGTH_BITS   = saw_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  saw_pkg::saw_cmd_t               cmd,
  output saw_pkg::saw_stat_t              stat,
  input  logic [saw_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [saw_pkg::S_TUSER_W-1:0]   s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [saw_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [saw_pkg::M_TUSER_W-1:0]   m_tuser,
  output logic                            m_tlast
);
  import saw_pkg::*;

  localparam int CNT_W     = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int SUM_W     = CNT_W + BYTE_W;
  localparam int LEN_EXT_W = (LENGTH_BITS > LEN_OUT_W) ? LENGTH_BITS : LEN_OUT_W;

  logic [BYTE_W-1:0]      mem [PAYLOAD_BYTES];
  logic [BYTE_W-1:0]      rd_data;

  logic [BYTE_W-1:0]      data_byte;
  logic [CSUM_W-1:0]      csum;
  logic                   present;
  logic                   packet_type;

  logic [CNT_W-1:0]       count;
  logic [SUM_W-1:0]       sum;
  logic                   ovf;
  logic                   pass;
  logic                   msg_end;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       addr_next;
  logic [LENGTH_BITS-1:0] length;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [LEN_EXT_W-1:0]   len_ext;
  logic [LEN_EXT_W-1:0]   len_inc_ext;

  logic                   room;
  logic                   wr_en;
  logic [SUM_W-1:0]       byte_ext;
  logic [SUM_W-1:0]       sum_next;
  logic                   ovf_next;
  logic                   match;

  logic                   out_valid;
  logic [KIND_W-1:0]      out_kind;
  logic [BYTE_W-1:0]      out_byte;
  logic                   out_complete;
  logic [LEN_OUT_W-1:0]   out_len;
  logic                   out_last;

  assign data_byte   = s_tdata[BYTE_W-1:0];
  assign csum        = s_tdata[BYTE_W+CSUM_W-1:BYTE_W];
  assign present     = s_tuser[0];
  assign packet_type = s_tuser[1];

  assign room     = count < CNT_W'(PAYLOAD_BYTES);
  assign wr_en    = cmd.take && present && room;
  assign byte_ext = {{(SUM_W-BYTE_W){data_byte[BYTE_W-1]}}, data_byte};
  assign sum_next = wr_en ? (sum + byte_ext) : sum;
  assign ovf_next = ovf | (cmd.take && present && !room);
  assign match    = {{(CSUM_W-SUM_W){sum_next[SUM_W-1]}}, sum_next} == csum;

  assign len_inc     = (length == {LENGTH_BITS{1'b1}}) ? length : length + LENGTH_BITS'(1);
  assign len_ext     = LEN_EXT_W'(length);
  assign len_inc_ext = LEN_EXT_W'(len_inc);

  assign addr_next = cmd.emit_byte ? idx + IDX_W'(1) : idx;

  assign stat.pass        = pass;
  assign stat.drain_empty = count == '0;
  assign stat.drain_last  = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign stat.out_free    = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= data_byte;
    end
    rd_data <= mem[addr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum       <= '0;
      ovf       <= 1'b0;
      pass      <= 1'b0;
      msg_end   <= 1'b0;
      idx       <= '0;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (wr_en) begin
          count <= count + CNT_W'(1);
        end
        sum <= sum_next;
        ovf <= ovf_next;
        if (s_tlast) begin
          pass    <= !ovf_next && match;
          msg_end <= packet_type;
        end
      end
      if (cmd.emit_byte) begin
        idx    <= addr_next;
        length <= len_inc;
      end
      if (cmd.emit_resp) begin
        count <= '0;
        sum   <= '0;
        ovf   <= 1'b0;
        idx   <= '0;
        if (pass && msg_end) begin
          length <= '0;
        end
      end
      if (cmd.emit_byte || cmd.emit_resp) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_kind     <= KIND_BYTE;
      out_byte     <= rd_data;
      out_complete <= 1'b0;
      out_len      <= len_inc_ext[LEN_OUT_W-1:0];
      out_last     <= 1'b0;
    end else if (cmd.emit_resp) begin
      out_kind     <= pass ? KIND_ACK : KIND_NACK;
      out_byte     <= '0;
      out_complete <= pass && msg_end;
      out_len      <= len_ext[LEN_OUT_W-1:0];
      out_last     <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_len, out_byte};
  assign m_tuser  = {out_complete, out_kind};
  assign m_tlast  = out_last;

endmodule

// File: design/stop_and_wait_receiver.sv
// top level of the stop-and-wait receiver with additive checksum
//
//  chan  dir  tdata (low bit up)            tuser (low bit up)             tlast
//  s_*   in   data_byte, received_checksum  byte_present, packet_type      end_of_packet
//  m_*   out  out_byte, message_length      result_kind, message_complete  last_of_run
//
// a byte in the middle of a packet is accepted without a stall; the end of a packet is
// followed by the first buffer read, each buffered byte on a match with no overflow
// and then the ack or nack, each result held while m_tready is low
// the payload buffer has a single read port, so the drain moves one byte a cycle unless m_tready stalls it
// synchronous reset clears the control state; the buffer is not cleared
module stop_and_wait_receiver #(
  parameter int PAYLOAD_BYTES = saw_pkg::PAYLOAD_BYTES_DEF,
  parameter int LENGTH_BITS   = saw_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [saw_pkg::S_TDATA_W-1:0]   s_tdata,   // data_byte, received_checksum
  input  logic [saw_pkg::S_TUSER_W-1:0]   s_tuser,   // byte_present, packet_type
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [saw_pkg::M_TDATA_W-1:0]   m_tdata,   // out_byte, message_length
  output logic [saw_pkg::M_TUSER_W-1:0]   m_tuser,   // result_kind, message_complete
  output logic                            m_tlast
);
  import saw_pkg::*;

  `include "assert_macros.svh"

  saw_cmd_t  cmd;
  saw_stat_t stat;

  saw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  saw_dpath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `ASSERT_NXT(a_eop_stalls_input, clk, rst, s_tvalid && s_tready && s_tlast, !s_tready)
  `ASSERT_IMP(a_resp_ends_run, clk, rst, m_tvalid && (m_tuser[1:0] != KIND_BYTE), m_tlast)
  `ASSERT_IMP(a_byte_not_last, clk, rst, m_tvalid && (m_tuser[1:0] == KIND_BYTE), !m_tlast)
  `ASSERT_IMP(a_complete_on_ack, clk, rst, m_tvalid && m_tuser[2], m_tuser[1:0] == KIND_ACK)

endmodule

// File: tb/tb_stop_and_wait_receiver.sv
// self-checking testbench for the stop-and-wait receiver with additive checksum
module tb_stop_and_wait_receiver;
  import saw_pkg::*;

  localparam int BUF_BYTES = PAYLOAD_BYTES_DEF;
  localparam longint LEN_CAP = (64'd1 << LENGTH_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_ITEMS = 40;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [BYTE_W-1:0]    data;
    logic                 complete;
    logic [LEN_OUT_W-1:0] length;
    logic                 last;
  } rx_result_t;

  typedef logic [7:0] data_q_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic m_tlast;

  // receiver-side model state
  logic [7:0] pkt_buf [BUF_BYTES];
  int pkt_fill = 0;
  int pkt_sum = 0;
  bit pkt_overflow = 0;
  longint msg_len = 0;

  rx_result_t pending_results[$];

  int errors = 0;
  int results_checked = 0;
  int items_sent = 0;
  int acks_seen = 0;
  int nacks_seen = 0;
  int completes_seen = 0;
  int burst_left = 0;
  int cycle_count = 0;

  stop_and_wait_receiver u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stall pattern: free-running, random, then periodic
  always @(posedge clk) begin
    case ((cycle_count / 150) % 3)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= ($urandom_range(0, 99) < 60);
      end
      default: begin
        m_tready <= ((cycle_count % 7) < 3);
      end
    endcase
  end

  function automatic int byte_sum(data_q_t q);
    int acc;
    acc = 0;
    foreach (q[i]) acc += int'($signed(q[i]));
    return acc;
  endfunction

  function automatic data_q_t random_bytes(int n);
    data_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom()));
    return q;
  endfunction

  task automatic push_result(logic [KIND_W-1:0] kind, logic [7:0] data, logic complete,
                             logic last);
    rx_result_t r;
    r.kind = kind;
    r.data = data;
    r.complete = complete;
    r.length = msg_len[LEN_OUT_W-1:0];
    r.last = last;
    pending_results.push_back(r);
  endtask

  // predicts the results of one accepted item and updates the packet state
  task automatic receive_item(logic [7:0] data, logic present, logic eop, logic msg_end,
                              logic signed [31:0] csum);
    if (present) begin
      if (pkt_fill < BUF_BYTES) begin
        pkt_buf[pkt_fill] = data;
        pkt_sum += int'($signed(data));
        pkt_fill++;
      end else begin
        pkt_overflow = 1;
      end
    end
    if (!eop) return;
    if (!pkt_overflow && pkt_sum == int'(csum)) begin
      for (int i = 0; i < pkt_fill; i++) begin
        if (msg_len < LEN_CAP) msg_len++;
        push_result(KIND_BYTE, pkt_buf[i], 1'b0, 1'b0);
      end
      push_result(KIND_ACK, 8'h00, msg_end, 1'b1);
      if (msg_end) msg_len = 0;
    end else begin
      push_result(KIND_NACK, 8'h00, 1'b0, 1'b1);
    end
    pkt_fill = 0;
    pkt_sum = 0;
    pkt_overflow = 0;
  endtask

  task automatic send_item(logic [7:0] data, logic present, logic eop, logic msg_end,
                           logic signed [31:0] csum);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {csum, data};
    s_tuser <= {msg_end, present};
    s_tlast <= eop;
    do @(posedge clk); while (!s_tready);
    if (present || eop) items_sent++;
    receive_item(data, present, eop, msg_end, csum);
  endtask

  task automatic send_packet(data_q_t bytes, logic msg_end, logic signed [31:0] csum,
                             bit empty_end, int absent_pct);
    bit closing;
    foreach (bytes[i]) begin
      if ($urandom_range(0, 99) < absent_pct)
        send_item(8'($urandom()), 1'b0, 1'b0, 1'($urandom()), 32'($urandom()));
      closing = (i == bytes.size() - 1) && !empty_end;
      if (closing) send_item(bytes[i], 1'b1, 1'b1, msg_end, csum);
      else send_item(bytes[i], 1'b1, 1'b0, 1'($urandom()), 32'($urandom()));
    end
    if (empty_end || bytes.size() == 0)
      send_item(8'($urandom()), 1'b0, 1'b1, msg_end, csum);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    rx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                   $time, m_tuser[1:0], m_tdata[7:0]);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_tuser[1:0] == KIND_ACK) acks_seen++;
        if (m_tuser[1:0] == KIND_NACK) nacks_seen++;
        if (m_tuser[2]) completes_seen++;
        check_field("result_kind", want.kind, m_tuser[1:0]);
        check_field("out_byte", want.data, m_tdata[7:0]);
        check_field("message_complete", want.complete, m_tuser[2]);
        check_field("message_length", want.length, m_tdata[23:8]);
        check_field("last_of_run", want.last, m_tlast);
      end
    end
  end

  // empty packets, good and bad checksum
  task automatic test_empty_packets();
    data_q_t none;
    send_packet(none, 1'b0, 32'sd0, 1, 0);
    send_packet(none, 1'b0, 32'sd1, 1, 0);
    send_packet(none, 1'b1, 32'sd0, 1, 0);
  endtask

  // sign handling of bytes, absent bytes mid-packet, message completion
  task automatic test_signed_bytes();
    data_q_t q;
    q = '{8'hFF};
    send_packet(q, 1'b0, -32'sd1, 0, 0);
    q = '{8'h80, 8'h7F, 8'h00};
    send_item(8'h55, 1'b0, 1'b0, 1'b1, 32'sd7);
    send_packet(q, 1'b0, -32'sd1, 1, 50);
    q = '{8'h01, 8'hFE};
    send_packet(q, 1'b1, -32'sd1, 0, 0);
  endtask

  task automatic test_checksum_extremes();
    data_q_t q;
    data_q_t none;
    q = '{8'h7F, 8'h7F};
    send_packet(q, 1'b0, 32'sh7FFFFFFF, 0, 0);
    send_packet(q, 1'b0, 32'sh80000000, 1, 0);
    send_packet(none, 1'b1, 32'sh80000000, 1, 0);
    send_packet(q, 1'b1, 32'sd254, 0, 0);
  endtask

  // full buffer accepted, one more byte forces a nack even with a matching sum
  task automatic test_buffer_limits();
    data_q_t q;
    q = random_bytes(BUF_BYTES);
    send_packet(q, 1'b1, byte_sum(q), 0, 0);
    q = random_bytes(BUF_BYTES + 1);
    send_packet(q, 1'b0, byte_sum(q[0:BUF_BYTES-1]), 0, 0);
    q = random_bytes(3);
    send_packet(q, 1'b1, byte_sum(q), 0, 0);
  endtask

  task automatic test_random_traffic();
    data_q_t q;
    int start_items;
    int pick;
    int n;
    logic signed [31:0] csum;
    bit paused;
    start_items = items_sent;
    paused = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) n = 0;
      else if (pick < 85) n = $urandom_range(1, 8);
      else if (pick < 95) n = $urandom_range(9, BUF_BYTES - 1);
      else n = $urandom_range(BUF_BYTES, BUF_BYTES + 3);
      q = random_bytes(n);
      pick = $urandom_range(0, 99);
      if (pick < 80) csum = byte_sum(q);
      else if (pick < 90) csum = byte_sum(q) + ($urandom_range(0, 1) ? 1 : -1);
      else csum = 32'($urandom());
      send_packet(q, ($urandom_range(0, 99) < 30), csum, ($urandom_range(0, 3) == 0), 10);
      if (!paused && items_sent - start_items > RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_packets();
    test_signed_bytes();
    test_checksum_extremes();
    test_buffer_limits();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input transfers and %0d result transfers", items_sent,
             results_checked);
    $display("packets acked %0d, nacked %0d, messages completed %0d", acks_seen, nacks_seen,
             completes_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
